// ----- src/wsce_pkg.sv -----
// ----------------------------------------------------------------------------
// wsce_pkg: shared types and constants of the client frame encoder
// Command, status and job codes, the job record handed from the front end
// to the back end, and the masking key byte selector.
// ----------------------------------------------------------------------------
`default_nettype none

package wsce_pkg;

  // Default width of the kept part of a frame length.
  localparam int unsigned LengthBitsDef = 64;
  // Width of the length field carried in a job.
  localparam int unsigned LenW = 64;

  localparam logic [31:0] DataMaskRst  = 32'h1234_5678;
  localparam logic [31:0] CloseMaskRst = 32'hABCD_EF01;

  localparam logic [7:0] OpText   = 8'h81;
  localparam logic [7:0] OpBinary = 8'h82;
  localparam logic [7:0] OpClose  = 8'h88;
  localparam logic [7:0] MaskBit  = 8'h80;
  localparam logic [7:0] LenMid   = 8'hFE;  // 126 with the mask bit
  localparam logic [7:0] LenLong  = 8'hFF;  // 127 with the mask bit

  localparam logic [63:0] ShortLenMax  = 64'd125;
  localparam logic [63:0] MidLenMax    = 64'd65535;
  localparam logic [63:0] ReasonLenMax = 64'd123;

  // Position of the first masking key byte for each length form.
  localparam logic [3:0] MaskStartShort = 4'd2;
  localparam logic [3:0] MaskStartMid   = 4'd4;
  localparam logic [3:0] MaskStartLong  = 4'd10;
  // Position of the final byte of a close header.
  localparam logic [3:0] CloseLastIdx   = 4'd7;

  typedef enum logic [2:0] {
    CMD_TEXT         = 3'd0,
    CMD_BINARY       = 3'd1,
    CMD_PAYLOAD      = 3'd2,
    CMD_CLOSE        = 3'd3,
    CMD_CONNECTED    = 3'd4,
    CMD_DISCONNECTED = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_OPEN = 2'd1,
    ST_NO_FRAME = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_DATA_MASK  = 1'b0,
    CFG_CLOSE_MASK = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    LINK_CONNECTING = 4'b0001,
    LINK_OPEN       = 4'b0010,
    LINK_CLOSING    = 4'b0100,
    LINK_CLOSED     = 4'b1000
  } link_e;

  typedef enum logic [1:0] {
    FORM_SHORT = 2'd0,
    FORM_MID   = 2'd1,
    FORM_LONG  = 2'd2
  } form_e;

  typedef enum logic [1:0] {
    JOB_SINGLE    = 2'd0,
    JOB_DATA_HDR  = 2'd1,
    JOB_CLOSE_HDR = 2'd2
  } job_kind_e;

  // One unit of work for the back end. A single job emits first_byte with
  // last and status as given; a header job emits a whole frame header.
  typedef struct packed {
    job_kind_e        kind;
    logic [7:0]       first_byte;
    logic             last;
    status_e          status;
    form_e            form;
    logic [LenW-1:0]  len;
    logic [15:0]      code;
    logic             zero_len;
  } job_t;

  // Key byte idx of a masking key; byte 0 is the most significant.
  function automatic logic [7:0] key_byte(input logic [31:0] key,
                                          input logic [1:0]  idx);
    logic [7:0] res;
    unique case (idx)
      2'd0:    res = key[31:24];
      2'd1:    res = key[23:16];
      2'd2:    res = key[15:8];
      default: res = key[7:0];
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/websocket_client_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// websocket_client_frame_encoder: masked client frame encoder
// Turns frame-start, payload, close and link commands into the byte stream
// of masked client frames, one byte per result.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the s_axis channel, with the command code in tuser and
// the length, data byte and close code in tdata. Each request that produces
// output yields a run of bytes on the m_axis channel: tdata is the wire byte,
// tlast marks the final byte of a frame and tuser carries a status. A
// non-zero status means the request was refused; tdata and tlast are zero.
// Link commands and unused codes produce no bytes.
// Payload streams at one byte per clock unless the receiver stalls.
// A frame header is 6, 8 or 14 bytes (by length form) and a close header
// 8; the byte sequencer emits one byte per cycle unless the receiver stalls.
// The first byte of a request goes through the job queue to the output register.
// A two-entry job queue sits between the command front end and the byte
// sequencer, so s_axis keeps taking requests while the output register waits.
// When the receiver stalls, the output byte holds and s_axis_tready drops
// once the queue fills. Reset leaves the link connecting, no frame open and
// both masking keys at their defaults. The key registers are written on the
// cfg channel, which is always ready; write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_client_frame_encoder #(
  parameter int unsigned LengthBits = wsce_pkg::LengthBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Command channel.
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [63:0] payload_length, [71:64] data_byte, [87:72] close_code
  input  wire logic [87:0]  s_axis_tdata_i,
  // [2:0] command
  input  wire logic [2:0]   s_axis_tuser_i,
  // Byte channel.
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [7:0] out_byte
  output logic [7:0]        m_axis_tdata_o,
  output logic              m_axis_tlast_o,
  // [1:0] status
  output logic [1:0]        m_axis_tuser_o,
  // Key register writes: index 0 data mask, index 1 close mask.
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [0:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  logic [31:0]     data_mask_q;
  logic [31:0]     close_mask_q;

  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  wsce_pkg::job_t  push_job;
  wsce_pkg::job_t  head_job;

  // The key registers are plain flops; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_mask_q  <= wsce_pkg::DataMaskRst;
      close_mask_q <= wsce_pkg::CloseMaskRst;
    end else if (cfg_valid_i) begin
      case (wsce_pkg::cfg_idx_e'(cfg_index_i))
        wsce_pkg::CFG_DATA_MASK:  data_mask_q  <= cfg_data_i;
        default:                  close_mask_q <= cfg_data_i;
      endcase
    end
  end

  // Front end: owns the link and frame state and masks payload bytes as
  // they are taken, so the back end never needs to look back at it.
  wsce_front #(
    .LengthBits (LengthBits)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .cmd_i            (s_axis_tuser_i),
    .payload_length_i (s_axis_tdata_i[63:0]),
    .data_byte_i      (s_axis_tdata_i[71:64]),
    .close_code_i     (s_axis_tdata_i[87:72]),
    .data_mask_i      (data_mask_q),
    .close_mask_i     (close_mask_q),
    .full_i           (full),
    .push_o           (push),
    .job_o            (push_job)
  );

  wsce_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  // Back end: one wire byte per cycle from the job at the queue head unless the receiver stalls.
  wsce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .empty_i      (empty),
    .pop_o        (pop),
    .data_mask_i  (data_mask_q),
    .close_mask_i (close_mask_q),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ----- src/wsce_fifo.sv -----
// ----------------------------------------------------------------------------
// wsce_fifo: two-entry job queue
// Decouples the front end from the back end so that each can stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module wsce_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire wsce_pkg::job_t  job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output wsce_pkg::job_t       job_o
);

  wsce_pkg::job_t mem_q [2];
  logic           wr_q, wr_d;
  logic           rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2 || pop_i))
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0)
    else $error("job queue read while empty");
`endif

endmodule

`default_nettype wire

// ----- src/wsce_front.sv -----
// ----------------------------------------------------------------------------
// wsce_front: command front end of the client frame encoder
// Accepts commands, keeps the link and frame state, masks payload bytes and
// queues one job per command that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module wsce_front #(
  parameter int unsigned LengthBits = wsce_pkg::LengthBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [2:0]   cmd_i,
  input  wire logic [63:0]  payload_length_i,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic [15:0]  close_code_i,
  input  wire logic [31:0]  data_mask_i,
  input  wire logic [31:0]  close_mask_i,
  input  wire logic         full_i,
  output logic              push_o,
  output wsce_pkg::job_t    job_o
);

  localparam int unsigned LenW = wsce_pkg::LenW;

  wsce_pkg::link_e         link_q, link_d;
  logic [LengthBits-1:0]   rem_q, rem_d;
  logic [1:0]              phase_q, phase_d;
  logic                    open_q, open_d;
  logic                    ucm_q, ucm_d;

  logic                    acc;
  logic [LengthBits-1:0]   len_clip;
  logic [LenW-1:0]         len_ext;
  logic [LengthBits-1:0]   rem_dec;
  logic                    rem_last;
  logic [7:0]              key;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;
  assign len_clip   = payload_length_i[LengthBits-1:0];
  assign len_ext    = LenW'(len_clip);
  assign rem_dec    = rem_q - LengthBits'(1);
  assign rem_last   = (rem_dec == '0);
  assign key        = wsce_pkg::key_byte(ucm_q ? close_mask_i : data_mask_i, phase_q);

  always_comb begin
    link_d  = link_q;
    rem_d   = rem_q;
    phase_d = phase_q;
    open_d  = open_q;
    ucm_d   = ucm_q;
    push_o  = 1'b0;
    job_o   = '0;
    if (acc) begin
      unique case (wsce_pkg::cmd_e'(cmd_i)) inside
        wsce_pkg::CMD_TEXT, wsce_pkg::CMD_BINARY: begin
          push_o = 1'b1;
          if (link_q != wsce_pkg::LINK_OPEN) begin
            job_o.kind   = wsce_pkg::JOB_SINGLE;
            job_o.status = wsce_pkg::ST_NOT_OPEN;
          end else begin
            job_o.kind       = wsce_pkg::JOB_DATA_HDR;
            job_o.first_byte = (wsce_pkg::cmd_e'(cmd_i) == wsce_pkg::CMD_TEXT) ?
                               wsce_pkg::OpText : wsce_pkg::OpBinary;
            job_o.len        = len_ext;
            job_o.zero_len   = (len_clip == '0);
            if (len_ext <= wsce_pkg::ShortLenMax) begin
              job_o.form = wsce_pkg::FORM_SHORT;
            end else if (len_ext <= wsce_pkg::MidLenMax) begin
              job_o.form = wsce_pkg::FORM_MID;
            end else begin
              job_o.form = wsce_pkg::FORM_LONG;
            end
            open_d  = (len_clip != '0);
            rem_d   = len_clip;
            phase_d = 2'd0;
            ucm_d   = 1'b0;
          end
        end
        wsce_pkg::CMD_PAYLOAD: begin
          push_o     = 1'b1;
          job_o.kind = wsce_pkg::JOB_SINGLE;
          if (!open_q) begin
            job_o.status = wsce_pkg::ST_NO_FRAME;
          end else begin
            job_o.first_byte = data_byte_i ^ key;
            job_o.last       = rem_last;
            job_o.status     = wsce_pkg::ST_OK;
            phase_d          = phase_q + 2'd1;
            rem_d            = rem_dec;
            open_d           = !rem_last;
          end
        end
        wsce_pkg::CMD_CLOSE: begin
          push_o = 1'b1;
          if (link_q == wsce_pkg::LINK_CLOSING || link_q == wsce_pkg::LINK_CLOSED) begin
            job_o.kind   = wsce_pkg::JOB_SINGLE;
            job_o.status = wsce_pkg::ST_NOT_OPEN;
          end else if (len_ext > wsce_pkg::ReasonLenMax) begin
            job_o.kind   = wsce_pkg::JOB_SINGLE;
            job_o.status = wsce_pkg::ST_TOO_LONG;
          end else begin
            job_o.kind     = wsce_pkg::JOB_CLOSE_HDR;
            job_o.len      = len_ext;
            job_o.code     = close_code_i;
            job_o.zero_len = (len_clip == '0);
            link_d         = wsce_pkg::LINK_CLOSING;
            open_d         = (len_clip != '0);
            rem_d          = len_clip;
            phase_d        = 2'd2;
            ucm_d          = 1'b1;
          end
        end
        wsce_pkg::CMD_CONNECTED: begin
          link_d = wsce_pkg::LINK_OPEN;
        end
        wsce_pkg::CMD_DISCONNECTED: begin
          link_d = wsce_pkg::LINK_CLOSED;
          open_d = 1'b0;
          rem_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q  <= wsce_pkg::LINK_CONNECTING;
      rem_q   <= '0;
      phase_q <= 2'd0;
      open_q  <= 1'b0;
      ucm_q   <= 1'b0;
    end else begin
      link_q  <= link_d;
      rem_q   <= rem_d;
      phase_q <= phase_d;
      open_q  <= open_d;
      ucm_q   <= ucm_d;
    end
  end

`ifndef ASSERT_OFF
  a_link_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(link_q))
    else $error("link state lost its one-hot code");
  a_open_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> rem_q != '0)
    else $error("frame open with no bytes owed");
`endif

endmodule

`default_nettype wire

// ----- src/wsce_back.sv -----
// ----------------------------------------------------------------------------
// wsce_back: byte sequencer of the client frame encoder
// Expands queued jobs into wire bytes, one per cycle, into an output
// register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module wsce_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire wsce_pkg::job_t job_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  input  wire logic [31:0]  data_mask_i,
  input  wire logic [31:0]  close_mask_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  output logic [1:0]        out_status_o
);

  logic [3:0]       idx_q, idx_d;
  logic             valid_q;
  logic [7:0]       byte_q;
  logic             last_q;
  wsce_pkg::status_e status_q;

  logic             load;
  logic [3:0]       mask_start;
  logic [3:0]       end_idx;
  logic [3:0]       key_off;
  logic [2:0]       len_sel;
  logic [7:0]       cur_byte;
  logic             cur_last;
  wsce_pkg::status_e cur_status;

  always_comb begin
    case (job_i.form)
      wsce_pkg::FORM_MID:  mask_start = wsce_pkg::MaskStartMid;
      wsce_pkg::FORM_LONG: mask_start = wsce_pkg::MaskStartLong;
      default:             mask_start = wsce_pkg::MaskStartShort;
    endcase
  end

  assign key_off = idx_q - mask_start;
  // Length bytes go out high byte first and end just before the key bytes.
  assign len_sel = 3'(mask_start - 4'd1 - idx_q);

  always_comb begin
    cur_byte   = 8'h00;
    cur_last   = 1'b0;
    cur_status = wsce_pkg::ST_OK;
    end_idx    = 4'd0;
    unique case (job_i.kind)
      wsce_pkg::JOB_DATA_HDR: begin
        end_idx = mask_start + 4'd3;
        if (idx_q >= mask_start) begin
          cur_byte = wsce_pkg::key_byte(data_mask_i, key_off[1:0]);
          cur_last = job_i.zero_len && (idx_q == end_idx);
        end else if (idx_q == 4'd0) begin
          cur_byte = job_i.first_byte;
        end else if (idx_q == 4'd1) begin
          case (job_i.form)
            wsce_pkg::FORM_MID:  cur_byte = wsce_pkg::LenMid;
            wsce_pkg::FORM_LONG: cur_byte = wsce_pkg::LenLong;
            default:             cur_byte = job_i.len[7:0] | wsce_pkg::MaskBit;
          endcase
        end else begin
          cur_byte = job_i.len[{len_sel, 3'b000} +: 8];
        end
      end
      wsce_pkg::JOB_CLOSE_HDR: begin
        end_idx = wsce_pkg::CloseLastIdx;
        case (idx_q) inside
          4'd0: cur_byte = wsce_pkg::OpClose;
          4'd1: cur_byte = (job_i.len[7:0] + 8'd2) | wsce_pkg::MaskBit;
          4'd2, 4'd3, 4'd4, 4'd5: begin
            cur_byte = wsce_pkg::key_byte(close_mask_i, key_off[1:0]);
          end
          4'd6: cur_byte = job_i.code[15:8] ^ wsce_pkg::key_byte(close_mask_i, 2'd0);
          default: begin
            cur_byte = job_i.code[7:0] ^ wsce_pkg::key_byte(close_mask_i, 2'd1);
            cur_last = job_i.zero_len;
          end
        endcase
      end
      default: begin
        cur_byte   = job_i.first_byte;
        cur_last   = job_i.last;
        cur_status = job_i.status;
      end
    endcase
  end

  assign load  = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = load && (idx_q == end_idx);

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = 4'd0;
    end else if (load) begin
      idx_d = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 4'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= cur_byte;
      last_q   <= cur_last;
      status_q <= cur_status;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign out_last_o   = last_q;
  assign out_status_o = status_q;

`ifndef ASSERT_OFF
  a_idx_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !pop_o) |=> idx_q == $past(idx_q) + 4'd1)
    else $error("header byte index did not advance");
  a_idx_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 4'd0 |-> !empty_i)
    else $error("header in progress with no queued job");
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q != wsce_pkg::ST_OK) |-> (!last_q && byte_q == 8'h00))
    else $error("error result carries data");
`endif

endmodule

`default_nettype wire
